@@ rtl/core/breathing_led_gamma_pwm_macros.svh @@
// Assertion macros for the breathing LED duty generator.
// Used by the top level; no other dependencies.
`ifndef BREATHING_LED_GAMMA_PWM_MACROS_SVH
`define BREATHING_LED_GAMMA_PWM_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BLGP_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// next-cycle implication
`define BLGP_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define BLGP_ASSERT_IMPL(label, clk, rst, pre, post, msg)
`define BLGP_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

@@ rtl/core/blgp_pkg.sv @@
// Shared types and constants of the breathing LED duty generator.
// No dependencies.
package blgp_pkg;

   localparam int TIME_W       = 32;
   localparam int PERIOD_W     = 16;
   localparam int ENTRY_W      = 10;
   localparam int DIV_W        = 32;
   localparam int DIV_STEPS    = DIV_W;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 16;

   localparam int MAX_DUTY_DEF    = 999;
   localparam int TABLE_DEPTH_DEF = 1024;

   localparam logic [PERIOD_W-1:0] PERIOD_FLOOR = 16'd100;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd2000;
   localparam logic                ENABLE_RESET = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 1'b1;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MOD,
      ST_FOLD,
      ST_MUL,
      ST_LOAD_SCALE,
      ST_SCALE,
      ST_READ,
      ST_EMIT,
      ST_ZERO
   } state_type;

   typedef struct packed {
      logic ram_wr;
      logic load_mod;
      logic div_step;
      logic fold;
      logic mul;
      logic load_scale;
      logic rd;
      logic emit;
      logic emit_zero;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic rsp_busy;
   } status_type;

endpackage

@@ rtl/core/blgp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module blgp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/blgp_ctrl.sv @@
// Sequencer of the breathing LED duty generator: input handshake,
// step counting for the shared divider, command generation. Uses blgp_pkg.
module blgp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_opcode,
   output logic                req_stall,
   input  blgp_pkg::status_type status,
   output blgp_pkg::cmd_type   cmd
);

   localparam int CNT_W = $clog2(blgp_pkg::DIV_STEPS);

   blgp_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                last_step;
   logic                accept;

   assign accept    = req_valid && (state_ff == blgp_pkg::ST_IDLE);
   assign last_step = (cnt_ff == CNT_W'(blgp_pkg::DIV_STEPS - 1));
   assign req_stall = (state_ff != blgp_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= blgp_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         blgp_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_opcode == blgp_pkg::OP_LOAD) begin
                  cmd.ram_wr = 1'b1;
               end else if (status.enable) begin
                  cmd.load_mod = 1'b1;
                  state_in     = blgp_pkg::ST_MOD;
               end else begin
                  state_in = blgp_pkg::ST_ZERO;
               end
            end
         end
         blgp_pkg::ST_MOD: begin
            cmd.div_step = 1'b1;
            if (last_step) begin
               state_in = blgp_pkg::ST_FOLD;
            end
         end
         blgp_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = blgp_pkg::ST_MUL;
         end
         blgp_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = blgp_pkg::ST_LOAD_SCALE;
         end
         blgp_pkg::ST_LOAD_SCALE: begin
            cmd.load_scale = 1'b1;
            state_in       = blgp_pkg::ST_SCALE;
         end
         blgp_pkg::ST_SCALE: begin
            cmd.div_step = 1'b1;
            if (last_step) begin
               state_in = blgp_pkg::ST_READ;
            end
         end
         blgp_pkg::ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = blgp_pkg::ST_EMIT;
         end
         blgp_pkg::ST_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = blgp_pkg::ST_IDLE;
            end
         end
         blgp_pkg::ST_ZERO: begin
            if (!status.rsp_busy) begin
               cmd.emit_zero = 1'b1;
               state_in      = blgp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = blgp_pkg::ST_IDLE;
         end
      endcase
      cnt_in = cmd.div_step ? cnt_ff + CNT_W'(1) : '0;
   end

endmodule

@@ rtl/core/blgp_dp.sv @@
// Datapath: config registers, shared restoring divider, fold and scale,
// gamma table and result register. Uses blgp_pkg and blgp_ram.
module blgp_dp #(
   parameter int MAX_DUTY    = blgp_pkg::MAX_DUTY_DEF,
   parameter int TABLE_DEPTH = blgp_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  blgp_pkg::cmd_type                 cmd,
   output blgp_pkg::status_type              status,
   input  logic                              csr_write,
   input  logic [blgp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [blgp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [blgp_pkg::TIME_W-1:0]       req_time_ms,
   input  logic [blgp_pkg::ENTRY_W-1:0]      req_entry_index,
   input  logic [blgp_pkg::ENTRY_W-1:0]      req_entry_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [blgp_pkg::ENTRY_W-1:0]      rsp_compare_value
);

   localparam int PW       = blgp_pkg::PERIOD_W;
   localparam int DW       = blgp_pkg::DIV_W;
   localparam int DIVR_W   = PW + 1;
   localparam int DUTY_W   = $clog2(MAX_DUTY + 1);
   localparam int PROD_W   = DIVR_W + DUTY_W;
   localparam int N_W      = PROD_W + 2;
   localparam int IDX_W    = $clog2(TABLE_DEPTH);
   localparam int STEP_LIM = (MAX_DUTY < TABLE_DEPTH - 1) ? MAX_DUTY : TABLE_DEPTH - 1;

   logic [PW-1:0]     period_ff, period_in;
   logic              enable_ff, enable_in;
   logic [DW-1:0]     quo_ff, quo_in;
   logic [DIVR_W-1:0] rem_ff, rem_in;
   logic [DIVR_W-1:0] divisor_ff, divisor_in;
   logic [DIVR_W-1:0] num_ff, num_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [blgp_pkg::ENTRY_W-1:0] rsp_value_ff, rsp_value_in;

   logic [DIVR_W:0]   trial;
   logic              trial_ge;
   logic [DIVR_W:0]   trial_diff;
   logic [PW-1:0]     t_mod;
   logic [DIVR_W-1:0] two_t;
   logic [N_W-1:0]    n_sum;
   logic [IDX_W-1:0]  rd_addr;
   logic              ram_we;
   logic [blgp_pkg::ENTRY_W-1:0] ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= blgp_pkg::PERIOD_RESET;
         enable_ff    <= blgp_pkg::ENABLE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         enable_ff    <= enable_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      divisor_ff   <= divisor_in;
      num_ff       <= num_in;
      prod_ff      <= prod_in;
      rsp_value_ff <= rsp_value_in;
   end

   // config writes, period saturates at the floor
   always_comb begin
      period_in = period_ff;
      enable_in = enable_ff;
      if (csr_write) begin
         case (csr_index)
            blgp_pkg::CSR_PERIOD: begin
               period_in = (csr_wdata < blgp_pkg::PERIOD_FLOOR) ?
                           blgp_pkg::PERIOD_FLOOR : csr_wdata[PW-1:0];
            end
            blgp_pkg::CSR_ENABLE: begin
               enable_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // one restoring divide step: dividend shifts out the top of quo_ff,
   // quotient bits shift in at the bottom
   assign trial      = {rem_ff, quo_ff[DW-1]};
   assign trial_ge   = (trial >= {1'b0, divisor_ff});
   assign trial_diff = trial - {1'b0, divisor_ff};

   assign t_mod = rem_ff[PW-1:0];
   assign two_t = {t_mod, 1'b0};
   assign n_sum = N_W'({prod_ff, 1'b0}) + N_W'(period_ff);

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      num_in     = num_ff;
      prod_in    = prod_ff;
      if (cmd.load_mod) begin
         quo_in     = req_time_ms;
         rem_in     = '0;
         divisor_in = {1'b0, period_ff};
      end
      if (cmd.load_scale) begin
         quo_in     = DW'(n_sum);
         rem_in     = '0;
         divisor_in = {period_ff, 1'b0};
      end
      if (cmd.div_step) begin
         quo_in = {quo_ff[DW-2:0], trial_ge};
         rem_in = trial_ge ? trial_diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      end
      if (cmd.fold) begin
         // rising half 2t, falling half 2(P-t)
         num_in = (two_t < {1'b0, period_ff}) ? two_t : {period_ff - t_mod, 1'b0};
      end
      if (cmd.mul) begin
         prod_in = PROD_W'(num_ff) * PROD_W'(MAX_DUTY);
      end
   end

   // quotient clamps to the duty ceiling and to the table's last index
   assign rd_addr = (quo_ff > DW'(STEP_LIM)) ? IDX_W'(STEP_LIM) : quo_ff[IDX_W-1:0];
   assign ram_we  = cmd.ram_wr && (32'(req_entry_index) < TABLE_DEPTH);

   blgp_ram #(
      .WIDTH (blgp_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_gamma (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_entry_index[IDX_W-1:0]),
      .wdata (req_entry_value),
      .re    (cmd.rd),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   always_comb begin
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit) begin
         rsp_value_in = ram_rdata;
         rsp_valid_in = 1'b1;
      end else if (cmd.emit_zero) begin
         rsp_value_in = '0;
         rsp_valid_in = 1'b1;
      end
   end

   assign status.enable   = enable_ff;
   assign status.rsp_busy = rsp_valid_ff && rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_compare_value = rsp_value_ff;

endmodule

@@ rtl/core/breathing_led_gamma_pwm.sv @@
// Channel   Handshake          Payload
// req       req_valid/stall    opcode, time_ms, entry_index, entry_value
// rsp       rsp_valid/stall    compare_value
// csr       csr_write          csr_index, csr_wdata
//
// A tick runs through two 32-step passes of the shared bit-serial divider
// (time mod period, then the duty scale) plus fold, multiply, table read and
// result load; a disabled tick goes straight to a zero result. A load leaves
// the sequencer idle, so the next item is taken in the cycle after it. Reset
// is synchronous; the gamma table is not cleared. A result waiting under
// rsp_stall holds the sequencer only at its final step.
// Top level of the breathing LED duty generator; uses blgp_pkg, blgp_ctrl,
// blgp_dp and the assertion macro header.
`include "breathing_led_gamma_pwm_macros.svh"
module breathing_led_gamma_pwm #(
   parameter int MAX_DUTY    = blgp_pkg::MAX_DUTY_DEF,
   parameter int TABLE_DEPTH = blgp_pkg::TABLE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [blgp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [blgp_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [blgp_pkg::TIME_W-1:0]       req_time_ms,
   input  logic [blgp_pkg::ENTRY_W-1:0]      req_entry_index,
   input  logic [blgp_pkg::ENTRY_W-1:0]      req_entry_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [blgp_pkg::ENTRY_W-1:0]      rsp_compare_value
);

   blgp_pkg::cmd_type    cmd;
   blgp_pkg::status_type status;

   blgp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .status     (status),
      .cmd        (cmd)
   );

   blgp_dp #(
      .MAX_DUTY    (MAX_DUTY),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_time_ms       (req_time_ms),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_compare_value (rsp_compare_value)
   );

   `BLGP_ASSERT_NEXT(a_tick_busy, clock, reset, req_valid && !req_stall && req_opcode == blgp_pkg::OP_TICK, req_stall, "tick transfer did not start the sequencer")
   `BLGP_ASSERT_NEXT(a_load_idle, clock, reset, req_valid && !req_stall && req_opcode == blgp_pkg::OP_LOAD, !req_stall, "table load did not finish in one cycle")
   `BLGP_ASSERT_NEXT(a_zero_value, clock, reset, cmd.emit_zero, rsp_valid && rsp_compare_value == '0, "disabled tick gave a nonzero result")
   `BLGP_ASSERT_IMPL(a_rsp_source, clock, reset, $rose(rsp_valid), $past(cmd.emit || cmd.emit_zero), "result appeared without an emit step")

endmodule
